// ===== rtl/mfc_pkg.sv =====
package mfc_pkg;

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = 2;
  localparam int unsigned CMDQ_CW    = 3;

  localparam logic [7:0] CH_M = 8'h4d;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_K = 8'h6b;

  // what one queue entry asks the back end to send
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_HDR   = 2'd1,
    CMD_TRK   = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  data;
    logic        add_close;
    logic [31:0] offset;
  } cmd_t;

  // "MThd" by index
  function automatic logic [7:0] hdr_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_M;
      2'd1:    c = CH_T;
      2'd2:    c = CH_H;
      default: c = CH_D;
    endcase
    return c;
  endfunction

  // "MTrk" by index
  function automatic logic [7:0] trk_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_M;
      2'd1:    c = CH_T;
      2'd2:    c = CH_R;
      default: c = CH_K;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mfc_front.sv =====
module mfc_front
  import mfc_pkg::*;
#(
  parameter int unsigned HEADER_BODY_BYTES = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  output logic       push_valid,
  output cmd_t       push_cmd,
  input  logic       q_full
);

  localparam int unsigned HL_W = $clog2(HEADER_BODY_BYTES + 1);

  typedef enum logic [5:0] {
    PH_SEEK   = 6'b000001,
    PH_MATCH  = 6'b000010,
    PH_HEADER = 6'b000100,
    PH_TAG    = 6'b001000,
    PH_LEN    = 6'b010000,
    PH_BODY   = 6'b100000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        mc_r, mc_nxt;
  logic              mg_r, mg_nxt;
  logic [HL_W-1:0]   hl_r, hl_nxt;
  logic [31:0]       chunk_r, chunk_nxt;
  logic [31:0]       body_r, body_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic [31:0]       found_r, found_nxt;

  logic              in_fire;
  logic              good;
  logic              body_vld;
  logic              close_vld;
  cmd_op_t           body_op;
  logic [1:0]        mc_inc;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;
  assign mc_inc    = mc_r + 2'd1;

  always_comb begin
    phase_nxt = phase_r;
    mc_nxt    = mc_r;
    mg_nxt    = mg_r;
    hl_nxt    = hl_r;
    chunk_nxt = chunk_r;
    body_nxt  = body_r;
    found_nxt = found_r;
    pos_nxt   = pos_r + 32'd1;
    good      = 1'b0;
    body_vld  = 1'b0;
    body_op   = CMD_BYTE;
    close_vld = 1'b0;

    case (phase_r)
      PH_SEEK: begin
        if (in_tdata == CH_M) begin
          found_nxt = pos_r;
          mc_nxt    = 2'd0;
          mg_nxt    = 1'b1;
          phase_nxt = PH_MATCH;
        end
      end
      PH_MATCH: begin
        good = mg_r && (in_tdata == hdr_char(mc_inc));
        if (mc_inc == 2'd3) begin
          if (good) begin
            body_vld  = 1'b1;
            body_op   = CMD_HDR;
            hl_nxt    = HL_W'(HEADER_BODY_BYTES);
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = PH_SEEK;
          end
          mc_nxt = 2'd0;
          mg_nxt = 1'b1;
        end else begin
          mc_nxt = mc_inc;
          mg_nxt = good;
        end
      end
      PH_HEADER: begin
        body_vld = 1'b1;
        hl_nxt   = hl_r - HL_W'(1);
        if (hl_r == HL_W'(1)) begin
          phase_nxt = PH_TAG;
          mc_nxt    = 2'd0;
          mg_nxt    = 1'b1;
        end
      end
      PH_TAG: begin
        good = mg_r && (in_tdata == trk_char(mc_r));
        if (mc_r == 2'd3) begin
          if (good) begin
            body_vld  = 1'b1;
            body_op   = CMD_TRK;
            chunk_nxt = '0;
            phase_nxt = PH_LEN;
          end else begin
            // unknown tag ends the file
            close_vld = 1'b1;
            phase_nxt = PH_SEEK;
          end
          mc_nxt = 2'd0;
          mg_nxt = 1'b1;
        end else begin
          mc_nxt = mc_inc;
          mg_nxt = good;
        end
      end
      PH_LEN: begin
        body_vld  = 1'b1;
        chunk_nxt = {chunk_r[23:0], in_tdata};
        if (mc_r == 2'd3) begin
          mc_nxt    = 2'd0;
          mg_nxt    = 1'b1;
          body_nxt  = chunk_nxt;
          phase_nxt = (chunk_nxt != 32'd0) ? PH_BODY : PH_TAG;
        end else begin
          mc_nxt = mc_inc;
        end
      end
      PH_BODY: begin
        body_vld = 1'b1;
        body_nxt = body_r - 32'd1;
        if (body_r == 32'd1) begin
          phase_nxt = PH_TAG;
          mc_nxt    = 2'd0;
          mg_nxt    = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_SEEK;
      end
    endcase

    if (in_tlast) begin
      if (phase_nxt inside {PH_HEADER, PH_TAG, PH_LEN, PH_BODY}) begin
        close_vld = 1'b1;
      end
      phase_nxt = PH_SEEK;
      mc_nxt    = 2'd0;
      mg_nxt    = 1'b1;
      hl_nxt    = '0;
      chunk_nxt = '0;
      body_nxt  = '0;
      pos_nxt   = '0;
      found_nxt = '0;
    end
  end

  always_comb begin
    push_valid         = in_fire && (body_vld || close_vld);
    push_cmd.op        = body_vld ? body_op : CMD_CLOSE;
    push_cmd.data      = in_tdata;
    push_cmd.add_close = close_vld;
    push_cmd.offset    = found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      mc_r    <= 2'd0;
      mg_r    <= 1'b1;
      hl_r    <= '0;
      chunk_r <= '0;
      body_r  <= '0;
      pos_r   <= '0;
      found_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      mc_r    <= mc_nxt;
      mg_r    <= mg_nxt;
      hl_r    <= hl_nxt;
      chunk_r <= chunk_nxt;
      body_r  <= body_nxt;
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> phase_r == PH_SEEK && pos_r == 32'd0 && found_r == 32'd0)
    else $error("stream end did not return parser to reset state");

  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> body_r != 32'd0)
    else $error("body phase with zero bytes left");

  a_close_op: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_cmd.op == CMD_CLOSE |-> push_cmd.add_close)
    else $error("close-only command without close flag");

endmodule

// ===== rtl/mfc_cmd_fifo.sv =====
module mfc_cmd_fifo
  import mfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic q_full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign q_full     = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = q_r[rd_ptr_r];
  assign do_push    = push_valid && !q_full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CMDQ_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_full)
    else $error("command pushed into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CW'(CMDQ_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || q_full) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/mfc_back.sv =====
module mfc_back
  import mfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic [2:0]  idx_r;
  logic [2:0]  n_body;
  logic [2:0]  n_total;
  logic        is_close;
  logic        is_last;
  logic        load;
  logic [7:0]  byte_nxt;
  logic        start_nxt;

  logic        vld_r;
  logic [7:0]  byte_r;
  logic        kind_r;
  logic        start_r;
  logic [31:0] offset_r;
  logic        last_r;

  always_comb begin
    case (head_cmd.op)
      CMD_BYTE:  n_body = 3'd1;
      CMD_HDR:   n_body = 3'd4;
      CMD_TRK:   n_body = 3'd4;
      default:   n_body = 3'd0;
    endcase
    n_total  = n_body + {2'b00, head_cmd.add_close};
    is_close = (idx_r >= n_body);
    is_last  = (idx_r == n_total - 3'd1);

    case (head_cmd.op)
      CMD_HDR:  byte_nxt = hdr_char(idx_r[1:0]);
      CMD_TRK:  byte_nxt = trk_char(idx_r[1:0]);
      default:  byte_nxt = head_cmd.data;
    endcase
    if (is_close) begin
      byte_nxt = 8'd0;
    end
    start_nxt = (head_cmd.op == CMD_HDR) && (idx_r == 3'd0);
  end

  assign load = head_valid && (!vld_r || out_tready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      kind_r   <= is_close;
      start_r  <= start_nxt;
      offset_r <= head_cmd.offset;
      last_r   <= is_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {offset_r, byte_r};
  assign out_tuser  = {start_r, kind_r};
  assign out_tlast  = last_r;

  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && kind_r |-> byte_r == 8'd0 && !start_r && last_r)
    else $error("close marker with data, start or not last");

  a_start_m: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && start_r |-> byte_r == CH_M && !last_r)
    else $error("file start not on header M");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < n_total)
    else $error("result index beyond command length");

endmodule

// ===== rtl/midi_file_carver_core.sv =====
// the first result of a byte passes the command queue, then the output register, to out_*
// throughput: one input byte per cycle; one result per cycle while out_tready is high,
// a found header or track tag expands to four results (five with a close at stream end)
// bursts are held in a four-entry command queue; in_tready drops only when it is full
// reset: synchronous active-low rst_n clears parser state, queue and output register
module midi_file_carver_core
  import mfc_pkg::*;
#(
  parameter int unsigned HEADER_BODY_BYTES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream: one scanned byte per item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  // output stream: carved bytes and close markers
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [39:8] file_offset
  output logic [1:0]  out_tuser,  // [0] item_kind, [1] file_start
  output logic        out_tlast   // last
);

  // front to queue
  logic push_valid;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // front end: tracks seek/match/header/tag/length/body phases and
  // turns each byte into at most one command for the back end
  mfc_front #(
    .HEADER_BODY_BYTES(HEADER_BODY_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  // short command queue so front and back stall independently
  mfc_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .q_full    (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  // back end: expands each command into results, one per cycle while out_tready allows,
  // through a registered output stage
  mfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
